[hw/rtl/dlgj_pkg.sv]
// types and constants shared by the dual lehmer generator judge
// used by dlgj_gen and dual_lehmer_generator_judge_unit, no dependencies
package dlgj_pkg;

    localparam int MOD_BITS   = 31;
    localparam int FAC_BITS   = 16;
    localparam int MASK_BITS  = 8;
    localparam int CNT_BITS   = 32;
    localparam int DIG_BITS   = 4;
    localparam int DIG_CNT    = FAC_BITS / DIG_BITS;
    localparam int DIG_IDX    = $clog2(DIG_CNT);
    localparam int PROD_BITS  = MOD_BITS + FAC_BITS;
    localparam int DPROD_BITS = MOD_BITS + DIG_BITS;
    localparam int TRY_BITS   = 17;
    localparam int ADDR_BITS  = 3;
    localparam int IN_BITS    = 8;
    localparam int OUT_BITS   = 96;

    localparam logic [MOD_BITS-1:0]  MODULUS    = {MOD_BITS{1'b1}};
    localparam logic [TRY_BITS-1:0]  PICK_LIMIT = 17'd65536;
    localparam logic [DIG_IDX-1:0]   DIG_LAST   = DIG_IDX'(DIG_CNT - 1);
    localparam logic [CNT_BITS-1:0]  CNT_MAX    = {CNT_BITS{1'b1}};

    localparam logic [MOD_BITS-1:0]  SEED_RST     = 31'd1;
    localparam logic [FAC_BITS-1:0]  FACTOR_A_RST = 16'd16807;
    localparam logic [FAC_BITS-1:0]  FACTOR_B_RST = 16'd48271;
    localparam logic [MASK_BITS-1:0] MASK_A_RST   = 8'd3;
    localparam logic [MASK_BITS-1:0] MASK_B_RST   = 8'd7;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_SEED_A   = 3'd0,
        REG_SEED_B   = 3'd1,
        REG_FACTOR_A = 3'd2,
        REG_FACTOR_B = 3'd3,
        REG_PICKY    = 3'd4,
        REG_MASK_A   = 3'd5,
        REG_MASK_B   = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        GEN_IDLE,
        GEN_MUL,
        GEN_RED
    } t_gen_state;

    typedef enum logic {
        TOP_IDLE,
        TOP_RUN
    } t_top_state;

    typedef struct packed {
        logic start;
        logic restart;
    } t_gen_ctl;

    typedef struct packed {
        logic                idle;
        logic [MOD_BITS-1:0] value;
    } t_gen_stat;

endpackage

[hw/rtl/dual_lehmer_generator_judge_unit.sv]
// top level of the dual lehmer generator judge: config registers, round
// control, match counter and output register; depends on dlgj_pkg, dlgj_gen
//
//  channel   dir  width  content (lowest bit first)
//  s_axis    in   8      restart, zero fill
//  m_axis    out  96     matched, match_count[31:0], value_a[30:0], value_b[30:0], zero
//  cfg       in   3+31   register index, write data (no read-back)
//
// one advance is 4 steps of a 31x4 digit multiply plus one fold
// a round ends once both generators are done, k the larger advance count of the two generators
// (k = 1 in plain mode, up to 65536 in picky mode)
// reset is synchronous active low and restores seeds, factors, masks and count
// a result waiting on o_m_tvalid holds the next round at its end, not its start
module dual_lehmer_generator_judge_unit #(
    parameter int COMPARE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dlgj_pkg::IN_BITS-1:0]       i_s_tdata,   // restart
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dlgj_pkg::OUT_BITS-1:0]      o_m_tdata,   // matched, count, value_a, value_b
    input  logic                               i_cfg_we,
    input  logic [dlgj_pkg::ADDR_BITS-1:0]     i_cfg_addr,
    input  logic [dlgj_pkg::MOD_BITS-1:0]      i_cfg_wdata
);

    logic [dlgj_pkg::MOD_BITS-1:0]   r_seed_a, r_seed_b;
    logic [dlgj_pkg::FAC_BITS-1:0]   r_factor_a, r_factor_b;
    logic                            r_picky;
    logic [dlgj_pkg::MASK_BITS-1:0]  r_mask_a, r_mask_b;

    dlgj_pkg::t_top_state            r_state, n_state;
    logic                            r_restart, n_restart;
    logic [dlgj_pkg::CNT_BITS-1:0]   r_total, n_total;
    logic                            r_out_valid, n_out_valid;
    logic [dlgj_pkg::OUT_BITS-1:0]   r_out_data, n_out_data;

    dlgj_pkg::t_gen_ctl              gen_ctl;
    dlgj_pkg::t_gen_stat             stat_a, stat_b;
    logic [dlgj_pkg::MASK_BITS-1:0]  eff_mask_a, eff_mask_b;
    logic                            hit;
    logic [dlgj_pkg::CNT_BITS-1:0]   base_total, new_total;
    logic                            accept, out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_a   <= dlgj_pkg::SEED_RST;
            r_seed_b   <= dlgj_pkg::SEED_RST;
            r_factor_a <= dlgj_pkg::FACTOR_A_RST;
            r_factor_b <= dlgj_pkg::FACTOR_B_RST;
            r_picky    <= 1'b0;
            r_mask_a   <= dlgj_pkg::MASK_A_RST;
            r_mask_b   <= dlgj_pkg::MASK_B_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                dlgj_pkg::REG_SEED_A:   r_seed_a   <= i_cfg_wdata;
                dlgj_pkg::REG_SEED_B:   r_seed_b   <= i_cfg_wdata;
                dlgj_pkg::REG_FACTOR_A: r_factor_a <= i_cfg_wdata[dlgj_pkg::FAC_BITS-1:0];
                dlgj_pkg::REG_FACTOR_B: r_factor_b <= i_cfg_wdata[dlgj_pkg::FAC_BITS-1:0];
                dlgj_pkg::REG_PICKY:    r_picky    <= i_cfg_wdata[0];
                dlgj_pkg::REG_MASK_A:   r_mask_a   <= i_cfg_wdata[dlgj_pkg::MASK_BITS-1:0];
                dlgj_pkg::REG_MASK_B:   r_mask_b   <= i_cfg_wdata[dlgj_pkg::MASK_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // a zero mask gives exactly one advance, which is plain mode
    assign eff_mask_a = r_picky ? r_mask_a : '0;
    assign eff_mask_b = r_picky ? r_mask_b : '0;

    dlgj_gen u_gen_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (gen_ctl),
        .i_seed   (r_seed_a),
        .i_factor (r_factor_a),
        .i_mask   (eff_mask_a),
        .o_stat   (stat_a)
    );

    dlgj_gen u_gen_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (gen_ctl),
        .i_seed   (r_seed_b),
        .i_factor (r_factor_b),
        .i_mask   (eff_mask_b),
        .o_stat   (stat_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dlgj_pkg::TOP_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_restart  <= n_restart;
        r_out_data <= n_out_data;
    end

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;

    assign hit = (stat_a.value[COMPARE_BITS-1:0] == stat_b.value[COMPARE_BITS-1:0]);
    assign base_total = r_restart ? '0 : r_total;
    assign new_total  = (hit && (base_total != dlgj_pkg::CNT_MAX))
                      ? base_total + dlgj_pkg::CNT_BITS'(1) : base_total;

    always_comb begin
        n_state         = r_state;
        n_restart       = r_restart;
        n_total         = r_total;
        n_out_valid     = r_out_valid && !i_m_tready;
        n_out_data      = r_out_data;
        gen_ctl.start   = 1'b0;
        gen_ctl.restart = i_s_tdata[0];
        o_s_tready      = 1'b0;
        case (r_state)
            dlgj_pkg::TOP_IDLE: begin
                o_s_tready = 1'b1;
                if (accept) begin
                    gen_ctl.start = 1'b1;
                    n_restart     = i_s_tdata[0];
                    n_state       = dlgj_pkg::TOP_RUN;
                end
            end
            dlgj_pkg::TOP_RUN: begin
                if (stat_a.idle && stat_b.idle && out_free) begin
                    n_total     = new_total;
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, stat_b.value, stat_a.value, new_total, hit};
                    n_state     = dlgj_pkg::TOP_IDLE;
                end
            end
            default: begin
                n_state = dlgj_pkg::TOP_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

[hw/rtl/dlgj_gen.sv]
// one lehmer generator: digit-serial multiply by the factor, fold mod 2^31-1,
// repeats while the value fails the mask, up to 65536 advances; depends on dlgj_pkg
module dlgj_gen (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dlgj_pkg::t_gen_ctl               i_ctl,
    input  logic [dlgj_pkg::MOD_BITS-1:0]    i_seed,
    input  logic [dlgj_pkg::FAC_BITS-1:0]    i_factor,
    input  logic [dlgj_pkg::MASK_BITS-1:0]   i_mask,
    output dlgj_pkg::t_gen_stat              o_stat
);

    dlgj_pkg::t_gen_state                r_state, n_state;
    logic [dlgj_pkg::MOD_BITS-1:0]       r_x, n_x;
    logic [dlgj_pkg::PROD_BITS-1:0]      r_acc, n_acc;
    logic [dlgj_pkg::FAC_BITS-1:0]       r_fac, n_fac;
    logic [dlgj_pkg::DIG_IDX-1:0]        r_dig, n_dig;
    logic [dlgj_pkg::TRY_BITS-1:0]       r_tries, n_tries;

    logic [dlgj_pkg::DIG_BITS-1:0]       digit;
    logic [dlgj_pkg::DPROD_BITS-1:0]     dprod;
    logic [dlgj_pkg::MOD_BITS:0]         fold;
    logic [dlgj_pkg::MOD_BITS-1:0]       red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dlgj_pkg::GEN_IDLE;
            r_x     <= dlgj_pkg::SEED_RST;
        end else begin
            r_state <= n_state;
            r_x     <= n_x;
        end
        r_acc   <= n_acc;
        r_fac   <= n_fac;
        r_dig   <= n_dig;
        r_tries <= n_tries;
    end

    // top digit of the factor first, accumulator shifts one digit per step
    assign digit = r_fac[dlgj_pkg::FAC_BITS-1 -: dlgj_pkg::DIG_BITS];
    assign dprod = {{dlgj_pkg::DIG_BITS{1'b0}}, r_x}
                 * {{dlgj_pkg::MOD_BITS{1'b0}}, digit};

    // bits above bit 30 fold onto the low bits, one subtract finishes it
    assign fold = {1'b0, r_acc[dlgj_pkg::MOD_BITS-1:0]}
                + {{(2*dlgj_pkg::MOD_BITS+1-dlgj_pkg::PROD_BITS){1'b0}},
                   r_acc[dlgj_pkg::PROD_BITS-1:dlgj_pkg::MOD_BITS]};
    assign red  = (fold >= {1'b0, dlgj_pkg::MODULUS})
                ? dlgj_pkg::MOD_BITS'(fold - {1'b0, dlgj_pkg::MODULUS})
                : fold[dlgj_pkg::MOD_BITS-1:0];

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_acc   = r_acc;
        n_fac   = r_fac;
        n_dig   = r_dig;
        n_tries = r_tries;
        case (r_state)
            dlgj_pkg::GEN_IDLE: begin
                if (i_ctl.start) begin
                    if (i_ctl.restart) begin
                        n_x = i_seed;
                    end
                    n_acc   = '0;
                    n_fac   = i_factor;
                    n_dig   = '0;
                    n_tries = '0;
                    n_state = dlgj_pkg::GEN_MUL;
                end
            end
            dlgj_pkg::GEN_MUL: begin
                n_acc = {r_acc[dlgj_pkg::PROD_BITS-dlgj_pkg::DIG_BITS-1:0],
                         {dlgj_pkg::DIG_BITS{1'b0}}}
                      + {{(dlgj_pkg::PROD_BITS-dlgj_pkg::DPROD_BITS){1'b0}}, dprod};
                n_fac = r_fac << dlgj_pkg::DIG_BITS;
                n_dig = r_dig + dlgj_pkg::DIG_IDX'(1);
                if (r_dig == dlgj_pkg::DIG_LAST) begin
                    n_state = dlgj_pkg::GEN_RED;
                end
            end
            dlgj_pkg::GEN_RED: begin
                n_x     = red;
                n_tries = r_tries + dlgj_pkg::TRY_BITS'(1);
                if (((red[dlgj_pkg::MASK_BITS-1:0] & i_mask) != '0)
                    && (n_tries < dlgj_pkg::PICK_LIMIT)) begin
                    n_acc   = '0;
                    n_fac   = i_factor;
                    n_dig   = '0;
                    n_state = dlgj_pkg::GEN_MUL;
                end else begin
                    n_state = dlgj_pkg::GEN_IDLE;
                end
            end
            default: begin
                n_state = dlgj_pkg::GEN_IDLE;
            end
        endcase
    end

    assign o_stat.idle  = (r_state == dlgj_pkg::GEN_IDLE);
    assign o_stat.value = r_x;

endmodule
